[hdl/sphm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphm_pkg
// Shared types and constants for the servo position PWM controller with
// homing: command and response words, action and result codes, register
// indexes and register reset values.
// ----------------------------------------------------------------------------
package sphm_pkg;

    // Build defaults for the top-level parameters
    localparam int MAX_POSITIONS_DEF = 8;
    localparam int COUNT_BITS_DEF    = 16;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int POSITION_W = 8;
    localparam int CUR_POS_W  = 3;
    localparam int RESULT_W   = 2;

    // Register widths and configuration port layout
    localparam int PERIOD_W    = 16;
    localparam int PULSE_MIN_W = 16;
    localparam int PULSE_STEP_W = 12;
    localparam int POS_COUNT_W = 4;
    localparam int SETTLE_W    = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 3;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_HOME = 2'd2;

    // Homing result codes
    localparam logic [RESULT_W-1:0] RES_NONE  = 2'd0;
    localparam logic [RESULT_W-1:0] RES_FOUND = 2'd1;
    localparam logic [RESULT_W-1:0] RES_FAIL  = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_MIN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_STEP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_POS_COUNT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE     = 3'd4;

    // Register reset values
    localparam logic [PERIOD_W-1:0]     PERIOD_RST     = 16'd2000;
    localparam logic [PULSE_MIN_W-1:0]  PULSE_MIN_RST  = 16'd100;
    localparam logic [PULSE_STEP_W-1:0] PULSE_STEP_RST = 12'd20;
    localparam logic [POS_COUNT_W-1:0]  POS_COUNT_RST  = 4'd6;
    localparam logic [SETTLE_W-1:0]     SETTLE_RST     = 20'd30000;

    // Command word
    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [POSITION_W-1:0] position;
        logic                  home_sensor;
    } cmd_word_t;

    // Response word
    typedef struct packed {
        logic                  pwm_level;
        logic [CUR_POS_W-1:0]  current_position;
        logic                  homing_busy;
        logic [RESULT_W-1:0]   home_result;
        logic                  set_rejected;
    } rsp_word_t;

endpackage

[hdl/servo_position_pwm_homing.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_position_pwm_homing
// Servo PWM position controller with a preloaded compare and a homing
// sequence that steps through the positions and samples a home sensor.
// ----------------------------------------------------------------------------
// One command word is taken per clock cycle while the response channel does
// not stall, and its response word appears in the response register on the
// next cycle. The controller state is updated at the same edge that takes the
// command; a command is taken whenever the response register is empty or its
// word is being taken in the same cycle. Each tick command advances the
// period counter by one, like a timer at its clock. Registers must be written
// through the cfg port while no command is in flight; this is not enforced.
module servo_position_pwm_homing #(
    parameter int MAX_POSITIONS = sphm_pkg::MAX_POSITIONS_DEF,
    parameter int COUNT_BITS    = sphm_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [sphm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sphm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // command channel
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  sphm_pkg::cmd_word_t                 cmd,
    // response channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output sphm_pkg::rsp_word_t                 rsp
);
    import sphm_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POSITIONS);
    localparam int CNT_W  = $clog2(MAX_POSITIONS + 1);
    localparam int PROD_W = IDX_W + PULSE_STEP_W;
    localparam int SUM_W  = ((PROD_W > PULSE_MIN_W) ? PROD_W : PULSE_MIN_W) + 1;
    localparam int WIDE_W = ((SUM_W > COUNT_BITS) ? SUM_W : COUNT_BITS) + 1;
    localparam int PER_W  = ((COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W) + 1;
    localparam logic [WIDE_W-1:0] CMP_MAX = WIDE_W'((WIDE_W'(1) << COUNT_BITS) - 1);

    // Configuration registers
    logic [PERIOD_W-1:0]     period_reg;
    logic [PULSE_MIN_W-1:0]  pulse_min_reg;
    logic [PULSE_STEP_W-1:0] pulse_step_reg;
    logic [POS_COUNT_W-1:0]  pos_count_reg;
    logic [SETTLE_W-1:0]     settle_reg;

    // Controller state
    logic [COUNT_BITS-1:0]   counter_reg, counter_next;
    logic [COUNT_BITS-1:0]   active_cmp_reg, active_cmp_next;
    logic [COUNT_BITS-1:0]   pending_cmp_reg, pending_cmp_next;
    logic [CUR_POS_W-1:0]    cur_pos_reg, cur_pos_next;
    logic                    homing_on_reg, homing_on_next;
    logic [IDX_W-1:0]        home_idx_reg, home_idx_next;
    logic [SETTLE_W-1:0]     settle_left_reg, settle_left_next;

    // Response register
    logic                    rsp_valid_reg;
    rsp_word_t               rsp_reg, rsp_next;

    // Datapath helpers
    logic                    cmd_accept;
    logic [CNT_W-1:0]        eff_count;
    logic [PERIOD_W-1:0]     period_eff;
    logic [SETTLE_W-1:0]     settle_load;
    logic [SETTLE_W-1:0]     settle_dec;
    logic                    move_en;
    logic [IDX_W-1:0]        move_pos;
    logic [PROD_W-1:0]       step_prod;
    logic [WIDE_W-1:0]       cmp_sum;
    logic [COUNT_BITS-1:0]   cmp_sat;
    logic [PER_W-1:0]        counter_inc;
    logic [RESULT_W-1:0]     result;
    logic                    rejected;

    // Handshake: take a word when the response register is free or draining
    assign cmd_stall  = rsp_valid_reg & rsp_stall;
    assign cmd_accept = cmd_valid & ~cmd_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Clamped position count, zero period and zero settle treated as one
    always_comb
    begin
        if (pos_count_reg == '0)
            eff_count = CNT_W'(1);
        else if (32'(pos_count_reg) > MAX_POSITIONS)
            eff_count = CNT_W'(MAX_POSITIONS);
        else
            eff_count = CNT_W'(pos_count_reg);
        period_eff  = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        settle_load = (settle_reg == '0) ? SETTLE_W'(1) : settle_reg;
    end

    // Compare value for the target position, saturated to counter full scale
    always_comb
    begin
        step_prod = PROD_W'(move_pos) * PROD_W'(pulse_step_reg);
        cmp_sum   = WIDE_W'(pulse_min_reg) + WIDE_W'(step_prod);
        cmp_sat   = (cmp_sum > CMP_MAX) ? COUNT_BITS'(CMP_MAX) : COUNT_BITS'(cmp_sum);
    end

    // Next state for one command word
    always_comb
    begin
        counter_next     = counter_reg;
        active_cmp_next  = active_cmp_reg;
        pending_cmp_next = pending_cmp_reg;
        cur_pos_next     = cur_pos_reg;
        homing_on_next   = homing_on_reg;
        home_idx_next    = home_idx_reg;
        settle_left_next = settle_left_reg;
        move_en          = 1'b0;
        move_pos         = '0;
        result           = RES_NONE;
        rejected         = 1'b0;
        counter_inc      = PER_W'(counter_reg) + PER_W'(1);
        settle_dec       = (settle_left_reg != '0) ? settle_left_reg - SETTLE_W'(1)
                                                   : settle_left_reg;

        case (cmd.action)
            ACT_TICK:
            begin
                // period counter with preload on wrap
                if (counter_inc >= PER_W'(period_eff))
                begin
                    counter_next    = '0;
                    active_cmp_next = pending_cmp_reg;
                end
                else
                begin
                    counter_next = COUNT_BITS'(counter_inc);
                end
                // homing step
                if (homing_on_reg)
                begin
                    settle_left_next = settle_dec;
                    if (settle_dec == '0)
                    begin
                        if (cmd.home_sensor)
                        begin
                            cur_pos_next   = '0;
                            homing_on_next = 1'b0;
                            result         = RES_FOUND;
                        end
                        else if (CNT_W'(home_idx_reg) + CNT_W'(1) >= eff_count)
                        begin
                            homing_on_next = 1'b0;
                            result         = RES_FAIL;
                        end
                        else
                        begin
                            home_idx_next    = home_idx_reg + IDX_W'(1);
                            move_en          = 1'b1;
                            move_pos         = home_idx_reg + IDX_W'(1);
                            settle_left_next = settle_load;
                        end
                    end
                end
            end
            ACT_SET:
            begin
                if (homing_on_reg || (cmd.position >= POSITION_W'(eff_count)))
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    move_en  = 1'b1;
                    move_pos = IDX_W'(cmd.position);
                end
            end
            ACT_HOME:
            begin
                if (!homing_on_reg)
                begin
                    homing_on_next   = 1'b1;
                    home_idx_next    = '0;
                    move_en          = 1'b1;
                    move_pos         = '0;
                    settle_left_next = settle_load;
                end
            end
            default:
            begin
                // unused code: state unchanged
            end
        endcase

        // move to the target position
        if (move_en)
        begin
            pending_cmp_next = cmp_sat;
            cur_pos_next     = CUR_POS_W'(move_pos);
        end

        rsp_next.pwm_level        = (counter_next < active_cmp_next);
        rsp_next.current_position = cur_pos_next;
        rsp_next.homing_busy      = homing_on_next;
        rsp_next.home_result      = result;
        rsp_next.set_rejected     = rejected;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RST;
            pulse_min_reg  <= PULSE_MIN_RST;
            pulse_step_reg <= PULSE_STEP_RST;
            pos_count_reg  <= POS_COUNT_RST;
            settle_reg     <= SETTLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERIOD:     period_reg     <= cfg_wdata[PERIOD_W-1:0];
                CFG_PULSE_MIN:  pulse_min_reg  <= cfg_wdata[PULSE_MIN_W-1:0];
                CFG_PULSE_STEP: pulse_step_reg <= cfg_wdata[PULSE_STEP_W-1:0];
                CFG_POS_COUNT:  pos_count_reg  <= cfg_wdata[POS_COUNT_W-1:0];
                CFG_SETTLE:     settle_reg     <= cfg_wdata[SETTLE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg     <= '0;
            active_cmp_reg  <= COUNT_BITS'(PULSE_MIN_RST);
            pending_cmp_reg <= COUNT_BITS'(PULSE_MIN_RST);
            cur_pos_reg     <= '0;
            homing_on_reg   <= 1'b0;
            home_idx_reg    <= '0;
            settle_left_reg <= '0;
        end
        else if (cmd_accept)
        begin
            counter_reg     <= counter_next;
            active_cmp_reg  <= active_cmp_next;
            pending_cmp_reg <= pending_cmp_next;
            cur_pos_reg     <= cur_pos_next;
            homing_on_reg   <= homing_on_next;
            home_idx_reg    <= home_idx_next;
            settle_left_reg <= settle_left_next;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd_accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
            rsp_reg <= rsp_next;
    end

    // Checks
    // a homing outcome is only reported once homing has stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.home_result != RES_NONE && rsp_reg.homing_busy))
        else $error("home result reported while homing still busy");

    // only a set word can be rejected
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && cmd.action != ACT_SET) |=> !rsp_reg.set_rejected)
        else $error("rejection flagged on a word that is not a set");

    // settle countdown is idle outside homing
    assert property (@(posedge clk) disable iff (!rst_n)
        !homing_on_reg |-> (settle_left_reg == '0))
        else $error("settle countdown running while not homing");

    // homing starts only from a start-homing word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(homing_on_reg) |-> $past(cmd_accept && cmd.action == ACT_HOME))
        else $error("homing started without a start-homing word");

endmodule
